// File: rtl/core/qte_pkg.sv
`timescale 1ns / 1ps

package qte_pkg;

    localparam int unsigned CORDIC_STEPS = 20;
    localparam int unsigned CORDIC_W     = 38;
    localparam int unsigned ANG_W        = 28;
    localparam int unsigned OPER_W       = 35;

    typedef logic signed [CORDIC_W-1:0] t_cval;
    typedef logic signed [ANG_W-1:0]    t_ang;
    typedef logic signed [OPER_W-1:0]   t_oper;

    localparam t_ang ANG_P180 = t_ang'(180 * 65536);
    localparam t_ang ANG_N180 = -t_ang'(180 * 65536);
    localparam t_ang ANG_P90  = t_ang'(90 * 65536);
    localparam t_ang ANG_N90  = -t_ang'(90 * 65536);

    localparam logic signed [CORDIC_W-1:0] NORM_LIMIT = CORDIC_W'(64'sd1 << 32);

    // Angle table in degrees*65536 for each CORDIC rotation.
    function automatic t_ang atan_entry(input logic [4:0] idx);
        t_ang v;
        case (idx)
            5'd0:  v = 28'sd2949120;
            5'd1:  v = 28'sd1740967;
            5'd2:  v = 28'sd919879;
            5'd3:  v = 28'sd466945;
            5'd4:  v = 28'sd234379;
            5'd5:  v = 28'sd117304;
            5'd6:  v = 28'sd58666;
            5'd7:  v = 28'sd29335;
            5'd8:  v = 28'sd14668;
            5'd9:  v = 28'sd7334;
            5'd10: v = 28'sd3667;
            5'd11: v = 28'sd1833;
            5'd12: v = 28'sd917;
            5'd13: v = 28'sd458;
            5'd14: v = 28'sd229;
            5'd15: v = 28'sd115;
            5'd16: v = 28'sd57;
            5'd17: v = 28'sd29;
            5'd18: v = 28'sd14;
            5'd19: v = 28'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Bundle of one atan2 lane between pipeline stages.
    typedef struct packed {
        t_cval x;
        t_cval y;
        t_ang  z;
        logic  fixed;
    } t_lane;

endpackage

// File: rtl/core/qte_terms.sv
`timescale 1ns / 1ps

// Products and atan2 operands, two register stages.
module qte_terms
    import qte_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [15:0] i_w,
    input  logic signed [15:0] i_x,
    input  logic signed [15:0] i_y,
    input  logic signed [15:0] i_z,
    output logic               o_valid,
    output t_oper              o_roll_y,
    output t_oper              o_roll_x,
    output t_oper              o_pitch_t,
    output t_oper              o_yaw_y,
    output t_oper              o_yaw_x
);

    logic [1:0]         r_v;
    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;
    t_oper              r_t0, r_t1, r_t2, r_t3, r_t4;
    t_oper              n_t2;

    localparam t_oper ONE_Q30 = t_oper'(64'sd1 << 30);

    always_comb begin
        n_t2 = 2 * (OPER_W'(r_wy) - OPER_W'(r_zx));
        if (n_t2 > ONE_Q30) begin
            n_t2 = ONE_Q30;
        end else if (n_t2 < -ONE_Q30) begin
            n_t2 = -ONE_Q30;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[0], i_valid};
        end
        r_wx <= i_w * i_x;  r_yz <= i_y * i_z;
        r_xx <= i_x * i_x;  r_yy <= i_y * i_y;
        r_wy <= i_w * i_y;  r_zx <= i_z * i_x;
        r_wz <= i_w * i_z;  r_xy <= i_x * i_y;
        r_zz <= i_z * i_z;
        r_t0 <= 2 * (OPER_W'(r_wx) + OPER_W'(r_yz));
        r_t1 <= ONE_Q30 - 2 * (OPER_W'(r_xx) + OPER_W'(r_yy));
        r_t2 <= n_t2;
        r_t3 <= 2 * (OPER_W'(r_wz) + OPER_W'(r_xy));
        r_t4 <= ONE_Q30 - 2 * (OPER_W'(r_yy) + OPER_W'(r_zz));
    end

    assign o_valid   = r_v[1];
    assign o_roll_y  = r_t0;
    assign o_roll_x  = r_t1;
    assign o_pitch_t = r_t2;
    assign o_yaw_y   = r_t3;
    assign o_yaw_x   = r_t4;

endmodule

// File: rtl/core/qte_sqrt.sv
`timescale 1ns / 1ps

// Pipelined integer square root of 2^60 - t^2, one result bit per stage.
module qte_sqrt
    import qte_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  t_oper        i_t,
    output logic         o_valid,
    output t_oper        o_t,
    output logic [30:0]  o_root
);

    localparam int unsigned NST = 31;

    logic [NST:0]        r_v;
    logic [61:0]         r_rem  [NST+1];
    logic [31:0]         r_root [NST+1];
    t_oper               r_t    [NST+1];
    logic signed [63:0]  r_sq;
    t_oper               r_tq;
    logic                r_vq;

    // Square in a stage of its own (|t| <= 2^30 fits 32 bits, so t^2 <= 2^60).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vq <= 1'b0;
        end else begin
            r_vq <= i_valid;
        end
        r_sq <= 64'(32'(i_t)) * 64'(32'(i_t));
        r_tq <= i_t;
    end

    always_comb begin
        r_rem[0]  = 62'((64'd1 << 60) - 64'(r_sq));
        r_root[0] = '0;
        r_t[0]    = r_tq;
        r_v[0]    = r_vq;
    end

    for (genvar g = 0; g < NST; g++) begin : g_st
        localparam int unsigned SH = 2 * (NST - 1 - g);
        logic [61:0] w_rem;
        logic [31:0] w_root;
        logic [63:0] w_trial;
        always_comb begin
            w_trial = ((64'(r_root[g]) << 2) | 64'd1) << SH;
            if (64'(r_rem[g]) >= w_trial) begin
                w_rem  = 62'(64'(r_rem[g]) - w_trial);
                w_root = {r_root[g][30:0], 1'b1};
            end else begin
                w_rem  = r_rem[g];
                w_root = {r_root[g][30:0], 1'b0};
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else begin
                r_v[g+1] <= r_v[g];
            end
            r_rem[g+1]  <= w_rem;
            r_root[g+1] <= w_root;
            r_t[g+1]    <= r_t[g];
        end
    end

    assign o_valid = r_v[NST];
    assign o_t     = r_t[NST];
    assign o_root  = r_root[NST][30:0];

endmodule

// File: rtl/core/qte_cordic.sv
`timescale 1ns / 1ps

// atan2 out in degrees*128: pre-rotation, normalize, 20 vectoring stages, round and clamp.
module qte_cordic
    import qte_pkg::*;
#(
    parameter int unsigned OUT_W = 16,
    parameter int          LIMIT = 23040
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  t_oper                   i_y,
    input  t_oper                   i_x,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_ang
);

    localparam int unsigned NSH = 6;   // normalize in shifts of 32,16,8,4,2,1

    t_lane r_pre;
    t_lane n_pre;
    logic  r_pv;
    t_lane r_nrm [NSH+1];
    logic  r_nv  [NSH+1];
    t_lane r_cl  [CORDIC_STEPS+1];
    logic  r_cv  [CORDIC_STEPS+1];
    logic  r_ov;
    logic signed [OUT_W-1:0] r_ang;

    // Stage: special cases and turn by 180 degrees for negative x.
    always_comb begin
        n_pre.fixed = 1'b0;
        n_pre.x     = CORDIC_W'(i_x);
        n_pre.y     = CORDIC_W'(i_y);
        n_pre.z     = '0;
        if (i_y == 0) begin
            n_pre.fixed = 1'b1;
            n_pre.z     = (i_x < 0) ? ANG_P180 : '0;
        end else if (i_x == 0) begin
            n_pre.fixed = 1'b1;
            n_pre.z     = (i_y > 0) ? ANG_P90 : ANG_N90;
        end else if (i_x < 0) begin
            n_pre.x = -CORDIC_W'(i_x);
            n_pre.y = -CORDIC_W'(i_y);
            n_pre.z = (i_y > 0) ? ANG_P180 : ANG_N180;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_valid;
        end
        r_pre <= n_pre;
    end

    always_comb begin
        r_nrm[0] = r_pre;
        r_nv[0]  = r_pv;
    end

    // Doubling until one magnitude reaches 2^32 equals the largest shift
    // keeping both below 2^33; binary search over the shift amount.
    for (genvar g = 0; g < NSH; g++) begin : g_nrm
        localparam int unsigned SH = 32 >> g;
        t_lane w_l;
        t_cval w_ay;
        logic  w_ok;
        always_comb begin
            w_l  = r_nrm[g];
            w_ay = w_l.y[CORDIC_W-1] ? -w_l.y : w_l.y;
            w_ok = (w_l.x < ((NORM_LIMIT <<< 1) >>> SH)) &&
                   (w_ay < ((NORM_LIMIT <<< 1) >>> SH)) &&
                   !w_l.fixed;
            if (w_ok) begin
                w_l.x = w_l.x <<< SH;
                w_l.y = w_l.y <<< SH;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_nv[g+1] <= 1'b0;
            end else begin
                r_nv[g+1] <= r_nv[g];
            end
            r_nrm[g+1] <= w_l;
        end
    end

    always_comb begin
        r_cl[0] = r_nrm[NSH];
        r_cv[0] = r_nv[NSH];
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
        t_lane w_l;
        t_cval w_dx, w_dy;
        always_comb begin
            w_l  = r_cl[g];
            w_dx = r_cl[g].y >>> g;
            w_dy = r_cl[g].x >>> g;
            if (!r_cl[g].fixed) begin
                if (r_cl[g].y > 0) begin
                    w_l.x = r_cl[g].x + w_dx;
                    w_l.y = r_cl[g].y - w_dy;
                    w_l.z = r_cl[g].z + atan_entry(5'(g));
                end else begin
                    w_l.x = r_cl[g].x - w_dx;
                    w_l.y = r_cl[g].y + w_dy;
                    w_l.z = r_cl[g].z - atan_entry(5'(g));
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[g+1] <= 1'b0;
            end else begin
                r_cv[g+1] <= r_cv[g];
            end
            r_cl[g+1] <= w_l;
        end
    end

    // Round half up to 1/128 degree and saturate.
    logic signed [ANG_W-10:0] w_q;
    always_comb begin
        w_q = (ANG_W-9)'(ANG_W'(r_cl[CORDIC_STEPS].z + t_ang'(256)) >>> 9);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_cv[CORDIC_STEPS];
        end
        if (w_q > (ANG_W-9)'(LIMIT)) begin
            r_ang <= OUT_W'(LIMIT);
        end else if (w_q < -(ANG_W-9)'(LIMIT)) begin
            r_ang <= -OUT_W'(LIMIT);
        end else begin
            r_ang <= OUT_W'(w_q);
        end
    end

    assign o_valid = r_ov;
    assign o_ang   = r_ang;

endmodule

// File: rtl/core/quaternion_to_euler_angles_top.sv
`timescale 1ns / 1ps

// Channel | Handshake                 | Payload
// --------+---------------------------+----------------------------------------
// command | start while busy low      | i_quat_w, i_quat_x, i_quat_y, i_quat_z
// result  | o_done, one cycle strobe  | o_roll_deg, o_pitch_deg, o_yaw_deg
//
// One quaternion may enter every cycle; busy is held low. The pitch path runs
// through products and operands, the square root (a square stage, then 31 root
// bits), pre-rotation, normalize, CORDIC steps and round and clamp. Roll and
// yaw pass a delay line matching the square root.
// Synchronous active-low reset drops every item in flight; the receiver
// cannot stall, so results leave on o_done without backpressure.
module quaternion_to_euler_angles_top
    import qte_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    output logic               o_done,
    output logic signed [15:0] o_roll_deg,
    output logic signed [14:0] o_pitch_deg,
    output logic signed [15:0] o_yaw_deg
);

    localparam int unsigned SQ_LAT = 32;

    logic  w_tv, w_sv, w_rv, w_pv, w_yv;
    t_oper w_ry, w_rx, w_pt, w_yy, w_yx, w_st;
    logic [30:0] w_root;
    t_oper r_dly [SQ_LAT+1][4];

    assign busy = 1'b0;

    qte_terms u_terms (
        .i_clk, .i_rst_n, .i_valid(start && !busy),
        .i_w(i_quat_w), .i_x(i_quat_x), .i_y(i_quat_y), .i_z(i_quat_z),
        .o_valid(w_tv), .o_roll_y(w_ry), .o_roll_x(w_rx), .o_pitch_t(w_pt),
        .o_yaw_y(w_yy), .o_yaw_x(w_yx)
    );

    qte_sqrt u_sqrt (
        .i_clk, .i_rst_n, .i_valid(w_tv), .i_t(w_pt),
        .o_valid(w_sv), .o_t(w_st), .o_root(w_root)
    );

    // Hold roll and yaw operands alongside the square root.
    always_comb begin
        r_dly[0][0] = w_ry;
        r_dly[0][1] = w_rx;
        r_dly[0][2] = w_yy;
        r_dly[0][3] = w_yx;
    end
    for (genvar g = 0; g < SQ_LAT; g++) begin : g_dly
        always_ff @(posedge i_clk) begin
            r_dly[g+1] <= r_dly[g];
        end
    end

    qte_cordic #(.OUT_W(16), .LIMIT(23040)) u_roll (
        .i_clk, .i_rst_n, .i_valid(w_sv), .i_y(r_dly[SQ_LAT][0]),
        .i_x(r_dly[SQ_LAT][1]), .o_valid(w_rv), .o_ang(o_roll_deg)
    );

    qte_cordic #(.OUT_W(15), .LIMIT(11520)) u_pitch (
        .i_clk, .i_rst_n, .i_valid(w_sv), .i_y(w_st),
        .i_x(OPER_W'(w_root)), .o_valid(w_pv), .o_ang(o_pitch_deg)
    );

    qte_cordic #(.OUT_W(16), .LIMIT(23040)) u_yaw (
        .i_clk, .i_rst_n, .i_valid(w_sv), .i_y(r_dly[SQ_LAT][2]),
        .i_x(r_dly[SQ_LAT][3]), .o_valid(w_yv), .o_ang(o_yaw_deg)
    );

    assign o_done = w_pv;

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rv == w_pv) && (w_yv == w_pv))
        else $error("angle lanes out of step");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_pitch_deg <= 15'sd11520) && (o_pitch_deg >= -15'sd11520))
        else $error("pitch out of range");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_roll_deg <= 16'sd23040) && (o_roll_deg >= -16'sd23040))
        else $error("roll out of range");

endmodule
